// ===== sv/gtd_pkg.sv =====
// ----------------------------------------------------------------------------
// gtd_pkg: shared types and constants of the Goertzel tone detector
// Field widths, fixed-point scaling, register indexes and the item types
// that travel between the front end, the sample queue, the core and the divider.
// ----------------------------------------------------------------------------
package gtd_pkg;

  localparam int SAMPLE_W    = 16;  // Q1.15 sample
  localparam int COS_W       = 19;  // 2*cos(w), Q.16
  localparam int SIN_W       = 18;  // sin(w), Q.16
  localparam int LEN_CFG_W   = 13;  // block length register
  localparam int CFG_W       = 19;  // widest register
  localparam int CFG_IDX_W   = 2;
  localparam int DELAY_W     = 48;  // recurrence state
  localparam int SUM_W       = 52;  // headroom for y and bin numerators
  localparam int SPLIT_W     = 24;  // delay word split for the multiplier
  localparam int MUL_B_W     = SPLIT_W + 1;
  localparam int MUL_W       = COS_W + MUL_B_W;
  localparam int PROD_W      = 68;  // full coef * delay product
  localparam int BIN_W       = 32;
  localparam int MUL_SHIFT   = 16;  // Q.16 scaling
  localparam int RE_SHIFT    = 17;  // half of 2*cos for the real part
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [LEN_CFG_W-1:0] BLOCK_LEN_RST = LEN_CFG_W'(256);
  localparam int LEN_CFG_MAX = (1 << LEN_CFG_W) - 1;

  localparam logic signed [DELAY_W-1:0] DELAY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic signed [DELAY_W-1:0] DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
  localparam logic signed [BIN_W-1:0]   BIN_MAX   = {1'b0, {(BIN_W-1){1'b1}}};
  localparam logic signed [BIN_W-1:0]   BIN_MIN   = {1'b1, {(BIN_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_COS  = 2'd0,
    CFG_COEF_SIN  = 2'd1,
    CFG_BLOCK_LEN = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } q_item_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [BIN_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/goertzel_tone_detector_top.sv =====
// ----------------------------------------------------------------------------
// goertzel_tone_detector_top: single-bin Goertzel tone detector
// Fixed-point Goertzel recurrence over a programmable block of samples,
// giving one saturated complex bin, divided by the block length, per block.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive sample_i and raise push; a beat is taken on a clock
//   edge with push high and full low. Result channel: while empty is low,
//   bin_real_o/bin_imag_o carry the oldest bin; pop takes it.
//   Config: write coef_cos (index 0), coef_sin (1) or block_len (2) through
//   cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle. Any listed write
//   also restarts the current block. Other indexes are ignored.
//   Sample handling: the core takes a sample only once it is through with the last,
//   sequencing one shared 19x25 multiplier over both halves of the 48-bit delay
//   word. After the last sample of a block come six multiply and rounding steps,
//   two one-bit-per-cycle divisions by the block length and a step that hands the
//   bin to the output register.
//   A four-beat sample queue sits in front of the core, so intake keeps going
//   while the core works; full rises only once the queue has filled.
//   If the receiver stalls, the finished bin holds in the output register and
//   the core keeps running samples until it has its next bin ready.
//   Reset: registers go to coef_cos = 0, coef_sin = 0, block_len = 256, the
//   delays and the sample count clear, queues empty.
// ----------------------------------------------------------------------------
module goertzel_tone_detector_top #(
  parameter int MAX_BLOCK_LEN = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [gtd_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [gtd_pkg::BIN_W-1:0]     bin_real_o,
  output logic signed [gtd_pkg::BIN_W-1:0]     bin_imag_o,
  input  logic                                 cfg_we_i,
  input  logic [gtd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [gtd_pkg::CFG_W-1:0]            cfg_wdata_i
);
  import gtd_pkg::*;

  // block lengths above the register range can never be reached
  localparam int LenCap = (MAX_BLOCK_LEN < LEN_CFG_MAX) ? MAX_BLOCK_LEN : LEN_CFG_MAX;
  localparam int LEN_W  = $clog2(LenCap + 1);

  // configuration registers
  logic signed [COS_W-1:0]  coef_cos_q;
  logic signed [SIN_W-1:0]  coef_sin_q;
  logic [LEN_CFG_W-1:0]     block_len_q;
  logic                     cfg_hit;
  logic [LEN_W-1:0]         eff_len;

  // decode the write; unknown indexes leave everything alone
  always_comb begin
    unique case (cfg_idx_i)
      CFG_COEF_COS, CFG_COEF_SIN, CFG_BLOCK_LEN: cfg_hit = cfg_we_i;
      default:                                   cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_cos_q  <= '0;
      coef_sin_q  <= '0;
      block_len_q <= BLOCK_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COEF_COS:  coef_cos_q  <= $signed(cfg_wdata_i[COS_W-1:0]);
        CFG_COEF_SIN:  coef_sin_q  <= $signed(cfg_wdata_i[SIN_W-1:0]);
        CFG_BLOCK_LEN: block_len_q <= cfg_wdata_i[LEN_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero counts as one, clamp to the largest supported block
  always_comb begin
    if (block_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(block_len_q) > LenCap) begin
      eff_len = LEN_W'(LenCap);
    end else begin
      eff_len = block_len_q[LEN_W-1:0];
    end
  end

  // front end and sample queue
  logic    q_wr, q_rd, q_valid;
  q_item_t q_wr_data, q_rd_data;

  gtd_front #(.LEN_W(LEN_W)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (cfg_hit),
    .push_i    (push),
    .full_i    (full),
    .sample_i  (sample_i),
    .len_i     (eff_len),
    .wr_o      (q_wr),
    .wr_data_o (q_wr_data)
  );

  gtd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_data),
    .valid_o   (q_valid)
  );

  // core and divider
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic                    res_valid, res_ready;
  logic signed [BIN_W-1:0] res_real, res_imag;

  gtd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (cfg_hit),
    .coef_cos_i   (coef_cos_q),
    .coef_sin_i   (coef_sin_q),
    .item_i       (q_rd_data),
    .item_valid_i (q_valid),
    .item_rd_o    (q_rd),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_real_o   (res_real),
    .res_imag_o   (res_imag)
  );

  gtd_div #(.LEN_W(LEN_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .den_i  (eff_len),
    .rsp_o  (div_rsp)
  );

  // output register: load when free or being drained this cycle
  logic                    out_valid_q;
  logic signed [BIN_W-1:0] bin_real_q, bin_imag_q;

  assign res_ready  = !out_valid_q || pop;
  assign empty      = !out_valid_q;
  assign bin_real_o = bin_real_q;
  assign bin_imag_o = bin_imag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bin_real_q  <= '0;
      bin_imag_q  <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      bin_real_q  <= res_real;
      bin_imag_q  <= res_imag;
    end else if (pop && out_valid_q) begin
      out_valid_q <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |=> out_valid_q && $stable(bin_real_q) && $stable(bin_imag_q))
    else $error("top: waiting bin changed");
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eff_len != '0)
    else $error("top: effective block length is zero");
`endif

endmodule

// ===== sv/gtd_front.sv =====
// ----------------------------------------------------------------------------
// gtd_front: sample intake
// Accepts samples, counts them against the block length and tags the last
// sample of each block before it enters the sample queue.
// ----------------------------------------------------------------------------
module gtd_front #(
  parameter int LEN_W = 13
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clr_i,
  input  logic                                 push_i,
  input  logic                                 full_i,
  input  logic signed [gtd_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic        [LEN_W-1:0]              len_i,
  output logic                                 wr_o,
  output gtd_pkg::q_item_t                     wr_data_o
);
  import gtd_pkg::*;

  logic [LEN_W-1:0] count_q, count_d;
  logic [LEN_W:0]   cnt_inc;
  logic             last;

  assign wr_o    = push_i && !full_i;
  assign cnt_inc = (LEN_W+1)'(count_q) + (LEN_W+1)'(1);
  assign last    = cnt_inc >= {1'b0, len_i};

  assign wr_data_o.sample = sample_i;
  assign wr_data_o.last   = last;

  always_comb begin
    count_d = count_q;
    if (clr_i) begin
      count_d = '0;
    end else if (wr_o) begin
      count_d = last ? '0 : cnt_inc[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  // the count never passes the block length
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, count_q} < {1'b0, len_i} || clr_i || !wr_o)
    else $error("front: sample count out of range");
`endif

endmodule

// ===== sv/gtd_queue.sv =====
// ----------------------------------------------------------------------------
// gtd_queue: sample queue
// Short first-in first-out queue that decouples intake from the core.
// ----------------------------------------------------------------------------
module gtd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  gtd_pkg::q_item_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output gtd_pkg::q_item_t rd_data_o,
  output logic             valid_o
);
  import gtd_pkg::*;

  q_item_t           entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o    = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o   = cnt_q != '0;
  assign rd_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + (QPTR_W+1)'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("queue: write while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> valid_o)
    else $error("queue: read while empty");
`endif

endmodule

// ===== sv/gtd_div.sv =====
// ----------------------------------------------------------------------------
// gtd_div: bin divider
// Restoring division of a signed numerator by the block length, one quotient
// bit per cycle, truncating toward zero and saturating to 32 bits.
// ----------------------------------------------------------------------------
module gtd_div #(
  parameter int LEN_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gtd_pkg::div_req_t req_i,
  input  logic [LEN_W-1:0] den_i,
  output gtd_pkg::div_rsp_t rsp_o
);
  import gtd_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic                    busy_q, fin_q, neg_q, done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [LEN_W-1:0]        rem_q;
  logic [SUM_W-1:0]        quo_q;
  logic signed [BIN_W-1:0] quot_q;

  logic [LEN_W:0]   rem_sh, rem_sub;
  logic             ge;
  logic [SUM_W-1:0] mag;
  logic             q_big;
  logic [BIN_W-1:0] q_low;

  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_i};
  assign rem_sub = rem_sh - {1'b0, den_i};
  assign mag     = req_i.num[SUM_W-1] ? SUM_W'(-req_i.num) : SUM_W'(req_i.num);
  assign q_big   = |quo_q[SUM_W-1:BIN_W-1];
  assign q_low   = quo_q[BIN_W-1:0];

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      neg_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        neg_q  <= req_i.num[SUM_W-1];
        quo_q  <= mag;
        rem_q  <= '0;
        cnt_q  <= CNT_W'(SUM_W);
      end else if (busy_q) begin
        // shift in one dividend bit, subtract when it fits
        rem_q <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        done_q <= 1'b1;
        if (q_big) begin
          quot_q <= neg_q ? BIN_MIN : BIN_MAX;
        end else begin
          quot_q <= neg_q ? $signed(-q_low) : $signed(q_low);
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q && !fin_q)
    else $error("div: start while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("div: done held more than one cycle");
`endif

endmodule

// ===== sv/gtd_core.sv =====
// ----------------------------------------------------------------------------
// gtd_core: Goertzel recurrence and bin computation
// Runs y = x + round(coef_cos*d1/2^16) - d2 on a shared 19x25 multiplier,
// then at block end forms the bin numerators and drives the divider.
// ----------------------------------------------------------------------------
module gtd_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clr_i,
  input  logic signed [gtd_pkg::COS_W-1:0]    coef_cos_i,
  input  logic signed [gtd_pkg::SIN_W-1:0]    coef_sin_i,
  input  gtd_pkg::q_item_t                    item_i,
  input  logic                                item_valid_i,
  output logic                                item_rd_o,
  output gtd_pkg::div_req_t                   div_req_o,
  input  gtd_pkg::div_rsp_t                   div_rsp_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic signed [gtd_pkg::BIN_W-1:0]    res_real_o,
  output logic signed [gtd_pkg::BIN_W-1:0]    res_imag_o
);
  import gtd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MLO, ST_MHI, ST_SUM, ST_UPD,
    ST_CLO, ST_CHI, ST_CSUM, ST_SLO, ST_SHI, ST_SSUM,
    ST_DRE, ST_DIM, ST_EMIT
  } state_e;

  state_e                    state_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic                      last_q;
  logic signed [DELAY_W-1:0] d1_q, d2_q;
  logic signed [MUL_W-1:0]   p_lo_q, p_hi_q;
  logic signed [SUM_W-1:0]   r_q, re_num_q;
  logic signed [BIN_W-1:0]   re_q, im_q;
  div_req_t                  div_req_q;

  logic                      use_sin, use_hi;
  logic signed [COS_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]  prod_full, rnd16, rnd17;
  logic signed [SUM_W-1:0]   scaled, y_full;
  logic signed [DELAY_W-1:0] y_sat;

  assign use_sin = (state_q == ST_SLO) || (state_q == ST_SHI);
  assign use_hi  = (state_q == ST_MHI) || (state_q == ST_CHI) || (state_q == ST_SHI);

  // shared multiplier: coef times one half of d1
  assign mul_a = use_sin ? COS_W'(coef_sin_i) : coef_cos_i;
  assign mul_b = use_hi ? MUL_B_W'($signed(d1_q[DELAY_W-1:SPLIT_W]))
                        : $signed({1'b0, d1_q[SPLIT_W-1:0]});
  assign mul_p = mul_a * mul_b;

  // recombine halves and round half up
  assign prod_full = (PROD_W'(p_hi_q) <<< SPLIT_W) + PROD_W'(p_lo_q);
  assign rnd16 = (prod_full + (PROD_W'(1) <<< (MUL_SHIFT - 1))) >>> MUL_SHIFT;
  assign rnd17 = (prod_full + (PROD_W'(1) <<< (RE_SHIFT - 1))) >>> RE_SHIFT;
  assign scaled = (state_q == ST_CSUM) ? rnd17[SUM_W-1:0] : rnd16[SUM_W-1:0];

  assign y_full = SUM_W'(x_q) + r_q - SUM_W'(d2_q);
  always_comb begin
    if (y_full > SUM_W'(DELAY_MAX)) begin
      y_sat = DELAY_MAX;
    end else if (y_full < SUM_W'(DELAY_MIN)) begin
      y_sat = DELAY_MIN;
    end else begin
      y_sat = y_full[DELAY_W-1:0];
    end
  end

  assign item_rd_o   = (state_q == ST_IDLE) && item_valid_i;
  assign res_valid_o = state_q == ST_EMIT;
  assign res_real_o  = re_q;
  assign res_imag_o  = im_q;
  assign div_req_o   = div_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      x_q       <= '0;
      last_q    <= 1'b0;
      d1_q      <= '0;
      d2_q      <= '0;
      p_lo_q    <= '0;
      p_hi_q    <= '0;
      r_q       <= '0;
      re_num_q  <= '0;
      re_q      <= '0;
      im_q      <= '0;
      div_req_q <= '0;
    end else begin
      div_req_q.start <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            x_q     <= item_i.sample;
            last_q  <= item_i.last;
            state_q <= ST_MLO;
          end
        end
        ST_MLO: begin
          p_lo_q  <= mul_p;
          state_q <= ST_MHI;
        end
        ST_MHI: begin
          p_hi_q  <= mul_p;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          r_q     <= scaled;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          d2_q    <= d1_q;
          d1_q    <= y_sat;
          state_q <= last_q ? ST_CLO : ST_IDLE;
        end
        ST_CLO: begin
          p_lo_q  <= mul_p;
          state_q <= ST_CHI;
        end
        ST_CHI: begin
          p_hi_q  <= mul_p;
          state_q <= ST_CSUM;
        end
        ST_CSUM: begin
          re_num_q <= scaled - SUM_W'(d2_q);
          state_q  <= ST_SLO;
        end
        ST_SLO: begin
          p_lo_q  <= mul_p;
          state_q <= ST_SHI;
        end
        ST_SHI: begin
          p_hi_q  <= mul_p;
          state_q <= ST_SSUM;
        end
        ST_SSUM: begin
          // keep the imaginary numerator, start the real division, open a new block
          r_q       <= scaled;
          div_req_q <= '{start: 1'b1, num: re_num_q};
          d1_q      <= '0;
          d2_q      <= '0;
          state_q   <= ST_DRE;
        end
        ST_DRE: begin
          if (div_rsp_i.done) begin
            re_q      <= div_rsp_i.quot;
            div_req_q <= '{start: 1'b1, num: r_q};
            state_q   <= ST_DIM;
          end
        end
        ST_DIM: begin
          if (div_rsp_i.done) begin
            im_q    <= div_rsp_i.quot;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (clr_i) begin
        d1_q <= '0;
        d2_q <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(re_q) && $stable(im_q))
    else $error("core: result changed while waiting");
  a_start_only_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> state_q == ST_DRE || state_q == ST_DIM)
    else $error("core: divider started outside bin phase");
`endif

endmodule
